>>> rtl/amerg_pkg.sv
`timescale 1ns / 1ps

package amerg_pkg;

  localparam int MAX_ADV_BYTES = 31;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_EN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 1'd1;

  localparam logic [1:0] OP_REPORT = 2'd0;
  localparam logic [1:0] OP_FLUSH  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  localparam logic [2:0] KIND_ADV_IND  = 3'd0;
  localparam logic [2:0] KIND_DIRECT   = 3'd1;
  localparam logic [2:0] KIND_SCAN_IND = 3'd2;
  localparam logic [2:0] KIND_SCAN_RSP = 3'd4;

  localparam logic [7:0] ADDR_KIND_MAX = 8'd3;
  localparam logic [7:0] PLEN_MAX      = 8'(MAX_ADV_BYTES);

  typedef struct packed {
    logic [47:0]       addr;
    logic [1:0]        akind;
    logic              conn;
    logic signed [7:0] rssi;
    logic [4:0]        adv_len;
  } entry_t;

  typedef struct packed {
    logic [47:0]       addr;
    logic [1:0]        akind;
    logic              conn;
    logic signed [7:0] rssi;
    logic [4:0]        adv_len;
    logic [4:0]        rsp_len;
    logic [3:0]        slot;
    logic              last;
  } result_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SRCH  = 7'b0000010,
    ST_HIT   = 7'b0000100,
    ST_MISS  = 7'b0001000,
    ST_FLUSH = 7'b0010000,
    ST_FL_LD = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

endpackage

>>> rtl/adv_report_scan_response_merger.sv
`timescale 1ns / 1ps
// channel | signals                                        | transfer when
// in      | in_valid, in_stall, opcode .. payload_len       | in_valid && !in_stall
// out     | out_valid, out_stall, found_addr .. last_flag   | out_valid && !out_stall
// cfg     | cfg_we, cfg_index, cfg_data                     | cfg_we
//
// one item at a time; in_stall is high from the transfer until the item is finished
// lookup: the slot ram is read one slot a cycle until a match or the last slot
// unheld report goes straight to emit; clear, ignored and malformed items finish in the transfer cycle
// flush: walks the slots in order, skipping empty ones and emitting each pending entry
// rst is synchronous: table empties at once, state and control flags reset, no ram clear pass
// a full output register holds the block in its emit step until out_stall drops

module adv_report_scan_response_merger import amerg_pkg::*; #(
  parameter int PENDING_SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           opcode,
  input  logic [2:0]           event_kind,
  input  logic [7:0]           addr_kind,
  input  logic [47:0]          device_addr,
  input  logic signed [7:0]    signal_rssi,
  input  logic [7:0]           payload_len,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [47:0]          found_addr,
  output logic [1:0]           found_addr_kind,
  output logic                 is_connectable,
  output logic signed [7:0]    found_rssi,
  output logic [4:0]           adv_len,
  output logic [4:0]           rsp_len,
  output logic [3:0]           slot_index,
  output logic                 last_flag
);

  localparam int SLOT_W = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;

  result_t           out_res;
  mem_ctl_t          mem_ctl;
  logic [SLOT_W-1:0] mem_addr;
  entry_t            mem_wdata;
  entry_t            mem_rdata;

  amerg_ctrl #(
    .PENDING_SLOTS(PENDING_SLOTS),
    .SLOT_W       (SLOT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .event_kind (event_kind),
    .addr_kind  (addr_kind),
    .device_addr(device_addr),
    .signal_rssi(signal_rssi),
    .payload_len(payload_len),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res),
    .mem_ctl    (mem_ctl),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata)
  );

  amerg_mem #(
    .DEPTH(PENDING_SLOTS),
    .AW   (SLOT_W)
  ) u_mem (
    .clk  (clk),
    .ctl  (mem_ctl),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  assign found_addr      = out_res.addr;
  assign found_addr_kind = out_res.akind;
  assign is_connectable  = out_res.conn;
  assign found_rssi      = out_res.rssi;
  assign adv_len         = out_res.adv_len;
  assign rsp_len         = out_res.rsp_len;
  assign slot_index      = out_res.slot;
  assign last_flag       = out_res.last;

endmodule

>>> rtl/amerg_mem.sv
`timescale 1ns / 1ps

module amerg_mem import amerg_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] addr,
  input  entry_t        wdata,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/amerg_ctrl.sv
`timescale 1ns / 1ps

module amerg_ctrl import amerg_pkg::*; #(
  parameter int PENDING_SLOTS = 16,
  parameter int SLOT_W        = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           opcode,
  input  logic [2:0]           event_kind,
  input  logic [7:0]           addr_kind,
  input  logic [47:0]          device_addr,
  input  logic signed [7:0]    signal_rssi,
  input  logic [7:0]           payload_len,
  output logic                 out_valid,
  input  logic                 out_stall,
  output result_t              out_res,
  output mem_ctl_t             mem_ctl,
  output logic [SLOT_W-1:0]    mem_addr,
  output entry_t               mem_wdata,
  input  entry_t               mem_rdata
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PENDING_SLOTS - 1);

  state_t                   state;
  logic                     scan_en;
  logic                     active;
  logic [PENDING_SLOTS-1:0] slot_valid;

  logic [47:0]       it_addr;
  logic [1:0]        it_akind;
  logic              it_conn;
  logic signed [7:0] it_rssi;
  logic [4:0]        it_plen;
  logic              it_rsp;
  logic              it_flush;

  logic [SLOT_W-1:0] rd_idx;
  logic              rd_act;
  logic              pipe_v;
  logic [SLOT_W-1:0] pipe_idx;
  logic [SLOT_W-1:0] hit_idx;
  entry_t            hit_data;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  result_t           res;

  logic    in_xfer;
  logic    out_free;
  logic    match;
  logic    bad_len;
  logic    bad_kind;
  logic    hold;
  entry_t  item_entry;
  entry_t  merged_entry;
  logic    flush_last;

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign bad_len  = (payload_len > PLEN_MAX);
  assign bad_kind = (addr_kind > ADDR_KIND_MAX);
  assign hold     = active && ((event_kind == KIND_ADV_IND) || (event_kind == KIND_SCAN_IND));

  assign match = pipe_v && slot_valid[pipe_idx] && (mem_rdata.addr == it_addr) &&
                 (mem_rdata.akind == it_akind);

  assign flush_last = ~|(slot_valid & ~(PENDING_SLOTS'(1) << rd_idx));

  always_comb begin
    item_entry.addr    = it_addr;
    item_entry.akind   = it_akind;
    item_entry.conn    = it_conn;
    item_entry.rssi    = it_rssi;
    item_entry.adv_len = it_plen;
    merged_entry       = hit_data;
    merged_entry.rssi  = it_rssi;
  end

  always_comb begin
    mem_ctl   = '0;
    mem_addr  = rd_idx;
    mem_wdata = item_entry;
    case (state)
      ST_SRCH: begin
        mem_ctl.rd = rd_act;
      end
      ST_HIT: begin
        mem_ctl.wr = 1'b1;
        mem_addr   = hit_idx;
        mem_wdata  = it_rsp ? merged_entry : item_entry;
      end
      ST_MISS: begin
        mem_ctl.wr = !it_rsp && free_found;
        mem_addr   = free_idx;
      end
      ST_FLUSH: begin
        mem_ctl.rd = slot_valid[rd_idx];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_en    <= 1'b0;
      active     <= 1'b0;
      slot_valid <= '0;
      out_valid  <= 1'b0;
      rd_act     <= 1'b0;
      pipe_v     <= 1'b0;
      free_found <= 1'b0;
      it_flush   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCAN_EN: scan_en <= cfg_data;
          CFG_ACTIVE:  active  <= cfg_data;
          default: begin
          end
        endcase
      end

      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            it_addr    <= device_addr;
            it_akind   <= addr_kind[1:0];
            it_conn    <= (event_kind == KIND_ADV_IND);
            it_rssi    <= signal_rssi;
            it_plen    <= payload_len[4:0];
            it_rsp     <= (event_kind == KIND_SCAN_RSP);
            it_flush   <= (opcode == OP_FLUSH);
            rd_idx     <= '0;
            rd_act     <= 1'b1;
            pipe_v     <= 1'b0;
            free_found <= 1'b0;
            res.addr    <= device_addr;
            res.akind   <= addr_kind[1:0];
            res.conn    <= (event_kind == KIND_ADV_IND);
            res.rssi    <= signal_rssi;
            res.adv_len <= payload_len[4:0];
            res.rsp_len <= '0;
            res.slot    <= '0;
            res.last    <= 1'b1;
            if (opcode == OP_CLEAR) begin
              slot_valid <= '0;
            end else if (opcode == OP_RSVD || !scan_en) begin
              state <= ST_IDLE;
            end else if (opcode == OP_FLUSH) begin
              state <= ST_FLUSH;
            end else if (event_kind == KIND_DIRECT) begin
              state <= ST_IDLE;
            end else if (event_kind == KIND_SCAN_RSP) begin
              if (active && !bad_kind && !bad_len) begin
                state <= ST_SRCH;
              end
            end else if (!bad_kind && !bad_len) begin
              state <= hold ? ST_SRCH : ST_EMIT;
            end
          end
        end
        ST_SRCH: begin
          if (rd_act) begin
            rd_idx <= rd_idx + SLOT_W'(1);
            rd_act <= (rd_idx != LAST_SLOT);
          end
          pipe_v   <= rd_act;
          pipe_idx <= rd_idx;
          if (match) begin
            hit_idx  <= pipe_idx;
            hit_data <= mem_rdata;
            state    <= ST_HIT;
          end else if (pipe_v) begin
            if (!slot_valid[pipe_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= pipe_idx;
            end
            if (pipe_idx == LAST_SLOT) begin
              state <= ST_MISS;
            end
          end
        end
        ST_HIT: begin
          if (it_rsp) begin
            slot_valid[hit_idx] <= 1'b0;
            res.addr    <= hit_data.addr;
            res.akind   <= hit_data.akind;
            res.conn    <= hit_data.conn;
            res.rssi    <= it_rssi;
            res.adv_len <= hit_data.adv_len;
            res.rsp_len <= it_plen;
            res.slot    <= 4'(hit_idx);
            res.last    <= 1'b1;
            state       <= ST_EMIT;
          end else begin
            slot_valid[hit_idx] <= 1'b1;
            state               <= ST_IDLE;
          end
        end
        ST_MISS: begin
          if (it_rsp) begin
            state <= ST_IDLE;
          end else if (free_found) begin
            slot_valid[free_idx] <= 1'b1;
            state                <= ST_IDLE;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_FLUSH: begin
          if (slot_valid[rd_idx]) begin
            state <= ST_FL_LD;
          end else if (rd_idx == LAST_SLOT) begin
            state <= ST_IDLE;
          end else begin
            rd_idx <= rd_idx + SLOT_W'(1);
          end
        end
        ST_FL_LD: begin
          slot_valid[rd_idx] <= 1'b0;
          res.addr    <= mem_rdata.addr;
          res.akind   <= mem_rdata.akind;
          res.conn    <= mem_rdata.conn;
          res.rssi    <= mem_rdata.rssi;
          res.adv_len <= mem_rdata.adv_len;
          res.rsp_len <= '0;
          res.slot    <= 4'(rd_idx);
          res.last    <= flush_last;
          state       <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_res <= res;
            if (!it_flush || rd_idx == LAST_SLOT) begin
              state <= ST_IDLE;
            end else begin
              rd_idx <= rd_idx + SLOT_W'(1);
              state  <= ST_FLUSH;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/amerg_chk.sv
`timescale 1ns / 1ps

module amerg_chk import amerg_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  opcode,
  input logic        out_valid,
  input logic        out_stall,
  input logic [47:0] found_addr,
  input logic [4:0]  rsp_len,
  input logic        last_flag
);

  // after reset the block is idle with nothing to deliver
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found_addr) && $stable(rsp_len) &&
    $stable(last_flag))
    else $error("stalled result changed");

  // clear and reserved opcodes finish in the transfer cycle
  a_quick_ops: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (opcode == OP_CLEAR || opcode == OP_RSVD) |=> !in_stall)
    else $error("clear or reserved opcode kept the block busy");

  // a merged scan response is always the only result of its item
  a_merge_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (rsp_len != 5'd0) |-> last_flag)
    else $error("merged result without last_flag");

endmodule

bind adv_report_scan_response_merger amerg_chk u_chk (.*);
